/* hdl/llae_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_pkg
// Shared types, constants and rule tables of the life-like automaton engine.
// ----------------------------------------------------------------------------
package llae_pkg;

    localparam int COLUMNS_DEFAULT = 64;
    localparam int ROWS            = 8;
    localparam int WORD_W          = 16;
    localparam int RULE_COUNT      = 6;
    localparam int RULE_W          = 3;
    localparam int GEN_W           = 6;
    localparam int MASK_W          = 9;
    localparam int COL_IN_W        = 6;

    localparam logic [GEN_W-1:0]  MAX_GEN_RESET = 6'd32;
    localparam logic [WORD_W-1:0] SEED_BAND0    = 16'h0300;
    localparam logic [WORD_W-1:0] SEED_BAND2    = 16'h00C0;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_DYING = 2'd1;
    localparam logic [1:0] CELL_OLD   = 2'd2;
    localparam logic [1:0] CELL_NEW   = 2'd3;

    typedef struct packed {
        logic                op;
        logic [COL_IN_W-1:0] column;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        red_byte;
        logic [7:0]        green_byte;
        logic [7:0]        blue_byte;
        logic [RULE_W-1:0] rule_number;
        logic [GEN_W-1:0]  generation_count;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_DONE
    } llae_state_t;

    typedef struct packed {
        logic rd_issue;
        logic gen_start;
        logic gen_read;
        logic gen_shift;
        logic gen_write;
        logic gen_finish;
        logic reseed;
        logic load_result;
        logic result_colour;
    } ctrl_cmd_t;

    typedef struct packed {
        logic gen_below;
        logic out_free;
    } dp_status_t;

    function automatic logic [MASK_W-1:0] survive_mask(input logic [RULE_W-1:0] idx);
        logic [MASK_W-1:0] m;
        unique case (idx)
            3'd0:    m = 9'h00C;
            3'd1:    m = 9'h129;
            3'd2:    m = 9'h002;
            3'd3:    m = 9'h0F0;
            3'd4:    m = 9'h1E6;
            3'd5:    m = 9'h001;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [MASK_W-1:0] birth_mask(input logic [RULE_W-1:0] idx);
        logic [MASK_W-1:0] m;
        unique case (idx)
            3'd0:    m = 9'h004;
            3'd1:    m = 9'h054;
            3'd2:    m = 9'h002;
            3'd3:    m = 9'h038;
            3'd4:    m = 9'h188;
            3'd5:    m = 9'h001;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

/* hdl/llae_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module llae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/llae_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_ctrl
// Sequencer: op decode, generation sweep timing and result hand-off.
// ----------------------------------------------------------------------------
module llae_ctrl #(
    parameter int COLUMNS = llae_pkg::COLUMNS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_op,
    output logic                  s_ready,
    input  llae_pkg::dp_status_t  status,
    output llae_pkg::ctrl_cmd_t   cmd
);

    localparam int PW = $clog2(COLUMNS + 4);

    llae_pkg::llae_state_t state_reg, state_next;
    logic [PW-1:0]         phase_reg, phase_next;
    logic                  colour_reg, colour_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= llae_pkg::ST_IDLE;
            phase_reg  <= '0;
            colour_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            colour_reg <= colour_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        colour_next = colour_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            llae_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                phase_next = '0;
                if (s_valid) begin
                    if (s_op == llae_pkg::OP_READ) begin
                        cmd.rd_issue = 1'b1;
                        colour_next  = 1'b1;
                        state_next   = llae_pkg::ST_DONE;
                    end else if (status.gen_below) begin
                        cmd.gen_start = 1'b1;
                        colour_next   = 1'b0;
                        state_next    = llae_pkg::ST_GEN;
                    end else begin
                        cmd.reseed  = 1'b1;
                        colour_next = 1'b0;
                        state_next  = llae_pkg::ST_DONE;
                    end
                end
            end
            llae_pkg::ST_GEN: begin
                // read k passes the RAM read register, then the window shift; writes trail
                cmd.gen_read  = (phase_reg <= PW'(COLUMNS + 1));
                cmd.gen_shift = (phase_reg >= PW'(1)) && (phase_reg <= PW'(COLUMNS + 2));
                cmd.gen_write = (phase_reg >= PW'(4));
                phase_next    = phase_reg + PW'(1);
                if (phase_reg == PW'(COLUMNS + 3)) begin
                    cmd.gen_finish = 1'b1;
                    state_next     = llae_pkg::ST_DONE;
                end
            end
            llae_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_result   = 1'b1;
                    cmd.result_colour = colour_reg;
                    state_next        = llae_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = llae_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/llae_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llae_datapath
// Grid buffers, column window, neighbour rule logic, state and result register.
// ----------------------------------------------------------------------------
module llae_datapath #(
    parameter int COLUMNS = llae_pkg::COLUMNS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  llae_pkg::in_item_t                s_item,
    input  logic                              cfg_we,
    input  logic [llae_pkg::GEN_W-1:0]        cfg_wdata,
    input  llae_pkg::ctrl_cmd_t               cmd,
    output llae_pkg::dp_status_t              status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output llae_pkg::out_item_t               m_item
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int BAND  = COLUMNS / 8;
    localparam int WW    = llae_pkg::WORD_W;

    // control state
    logic                          cur_buf_reg, cur_buf_next;
    logic [llae_pkg::RULE_W-1:0]   rule_reg, rule_next;
    logic [llae_pkg::GEN_W-1:0]    gen_reg, gen_next;
    logic [llae_pkg::GEN_W-1:0]    max_gen_reg, max_gen_next;
    logic [1:0]                    seeded_reg, seeded_next;
    logic [CW-1:0]                 rd_col_reg, rd_col_next;
    logic [CW-1:0]                 wr_col_reg, wr_col_next;
    logic                          m_valid_reg, m_valid_next;

    // payload
    logic [WW-1:0]                 win_prev_reg, win_cur_reg, win_next_reg;
    logic                          rd_seed_reg;
    logic [WW-1:0]                 rd_seed_word_reg;
    logic                          col_ok_reg;
    llae_pkg::out_item_t           m_item_reg;

    logic                          dst_buf;
    logic [31:0]                   col_in32;
    logic [CW-1:0]                 rd_col;
    logic [31:0]                   seed_col32;
    logic [2:0]                    seed_band;
    logic [WW-1:0]                 seed_word;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [AW-1:0]                 ram_waddr;
    logic [WW-1:0]                 ram_rdata;
    logic [WW-1:0]                 dout_eff;
    logic [llae_pkg::ROWS-1:0]     alv_prev, alv_cur, alv_next;
    logic [llae_pkg::MASK_W-1:0]   smask, bmask;
    logic [3:0]                    cnt;
    logic [WW-1:0]                 new_word;
    llae_pkg::out_item_t           result_item;

    assign dst_buf  = ~cur_buf_reg;
    assign col_in32 = 32'(s_item.column);
    assign rd_col   = cmd.rd_issue ? col_in32[CW-1:0] : rd_col_reg;

    // seed pattern of the addressed column: band index from boundary compares
    always_comb begin
        seed_col32 = 32'(rd_col);
        seed_band  = '0;
        seed_word  = '0;
        for (int k = 1; k < 8; k++) begin
            if (seed_col32 >= 32'(k * BAND)) begin
                seed_band = seed_band + 3'd1;
            end
        end
        if (seed_col32 < 32'(8 * BAND)) begin
            unique case (seed_band[1:0])
                2'd0:    seed_word = llae_pkg::SEED_BAND0;
                2'd2:    seed_word = llae_pkg::SEED_BAND2;
                default: seed_word = '0;
            endcase
        end
    end

    assign ram_re    = cmd.rd_issue | cmd.gen_read;
    assign ram_raddr = {cur_buf_reg, rd_col};
    assign ram_waddr = {dst_buf, wr_col_reg};

    llae_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (cmd.gen_write),
        .waddr (ram_waddr),
        .wdata (new_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dout_eff = rd_seed_reg ? rd_seed_word_reg : ram_rdata;

    // next generation of the window centre column
    always_comb begin
        for (int r = 0; r < llae_pkg::ROWS; r++) begin
            alv_prev[r] = win_prev_reg[2 * (7 - r) + 1];
            alv_cur[r]  = win_cur_reg[2 * (7 - r) + 1];
            alv_next[r] = win_next_reg[2 * (7 - r) + 1];
        end
    end

    assign smask = llae_pkg::survive_mask(rule_reg);
    assign bmask = llae_pkg::birth_mask(rule_reg);

    always_comb begin
        new_word = '0;
        cnt      = '0;
        for (int r = 0; r < llae_pkg::ROWS; r++) begin
            cnt = 4'(alv_prev[r]) + 4'(alv_next[r]);
            if (r > 0) begin
                cnt = cnt + 4'(alv_prev[r-1]) + 4'(alv_cur[r-1]) + 4'(alv_next[r-1]);
            end
            if (r < 7) begin
                cnt = cnt + 4'(alv_prev[r+1]) + 4'(alv_cur[r+1]) + 4'(alv_next[r+1]);
            end
            if (alv_cur[r]) begin
                new_word[2*(7-r) +: 2] = smask[cnt] ? llae_pkg::CELL_OLD : llae_pkg::CELL_DYING;
            end else begin
                new_word[2*(7-r) +: 2] = bmask[cnt] ? llae_pkg::CELL_NEW : llae_pkg::CELL_EMPTY;
            end
        end
    end

    // colour decode of the read column
    always_comb begin
        result_item                  = '0;
        result_item.rule_number      = rule_reg;
        result_item.generation_count = gen_reg;
        if (cmd.result_colour && col_ok_reg) begin
            for (int i = 0; i < 8; i++) begin
                result_item.red_byte[i]   = dout_eff[2*i+1];
                result_item.green_byte[i] = dout_eff[2*i+1] & dout_eff[2*i];
                result_item.blue_byte[i]  = dout_eff[2*i];
            end
        end
    end

    always_comb begin
        cur_buf_next = cur_buf_reg;
        rule_next    = rule_reg;
        gen_next     = gen_reg;
        max_gen_next = max_gen_reg;
        seeded_next  = seeded_reg;
        rd_col_next  = rd_col_reg;
        wr_col_next  = wr_col_reg;
        m_valid_next = m_valid_reg;
        if (cfg_we) begin
            max_gen_next = cfg_wdata;
        end
        if (cmd.gen_start) begin
            rd_col_next          = CW'(COLUMNS - 1);
            wr_col_next          = '0;
            seeded_next[dst_buf] = 1'b0;
        end
        if (cmd.gen_read) begin
            rd_col_next = (rd_col_reg == CW'(COLUMNS - 1)) ? '0 : rd_col_reg + CW'(1);
        end
        if (cmd.gen_write) begin
            wr_col_next = (wr_col_reg == CW'(COLUMNS - 1)) ? '0 : wr_col_reg + CW'(1);
        end
        if (cmd.gen_finish) begin
            gen_next     = gen_reg + llae_pkg::GEN_W'(1);
            cur_buf_next = dst_buf;
        end
        if (cmd.reseed) begin
            rule_next = (rule_reg == llae_pkg::RULE_W'(llae_pkg::RULE_COUNT - 1)) ?
                        '0 : rule_reg + llae_pkg::RULE_W'(1);
            gen_next             = '0;
            seeded_next[dst_buf] = 1'b1;
            cur_buf_next         = dst_buf;
        end
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_buf_reg <= 1'b0;
            rule_reg    <= '0;
            gen_reg     <= '0;
            max_gen_reg <= llae_pkg::MAX_GEN_RESET;
            seeded_reg  <= 2'b01;
            rd_col_reg  <= '0;
            wr_col_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_buf_reg <= cur_buf_next;
            rule_reg    <= rule_next;
            gen_reg     <= gen_next;
            max_gen_reg <= max_gen_next;
            seeded_reg  <= seeded_next;
            rd_col_reg  <= rd_col_next;
            wr_col_reg  <= wr_col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_seed_reg      <= seeded_reg[cur_buf_reg];
            rd_seed_word_reg <= seed_word;
        end
        if (cmd.rd_issue) begin
            col_ok_reg <= (col_in32 < 32'(COLUMNS));
        end
        if (cmd.gen_shift) begin
            win_prev_reg <= win_cur_reg;
            win_cur_reg  <= win_next_reg;
            win_next_reg <= dout_eff;
        end
        if (cmd.load_result) begin
            m_item_reg <= result_item;
        end
    end

    assign status.gen_below = (gen_reg < max_gen_reg);
    assign status.out_free  = ~m_valid_reg | m_ready;
    assign m_valid          = m_valid_reg;
    assign m_item           = m_item_reg;

endmodule

/* hdl/life_like_automaton_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_engine_unit
// Two-buffer 8-row life-like automaton with rule cycling and colour readout.
// ----------------------------------------------------------------------------
// One op is handled at a time and every op returns one result. A generation
// step sweeps the grid through the single read port of the grid RAM, one
// column a cycle with a three-column window. A reseeding step is taken when
// the generation count is at or above max_generations. Reseeding steps the
// rule and marks the buffer as holding the stripe pattern, so there is no fill
// pass, also after reset. Reads of a column at or beyond COLUMNS return zero
// colour bytes. max_generations may be written only while idle.
module life_like_automaton_engine_unit #(
    parameter int COLUMNS = llae_pkg::COLUMNS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  llae_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output llae_pkg::out_item_t           m_item,
    input  logic                          cfg_we,
    input  logic [llae_pkg::GEN_W-1:0]    cfg_wdata
);

    llae_pkg::ctrl_cmd_t  cmd;
    llae_pkg::dp_status_t status;

    llae_ctrl #(
        .COLUMNS (COLUMNS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_item.op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    llae_datapath #(
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
